// ===== rtl/core/gcsd_pkg.sv =====
// Shared types and constants of the glyph contour segment decoder.
// No dependencies; every other file of the block imports it.
package gcsd_pkg;

	localparam int OUT_W     = 16;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 8'd1;

	localparam logic [15:0] SHIFT_X_RESET = 16'd0;
	localparam logic [15:0] SHIFT_Y_RESET = 16'd30;

	localparam logic SEG_LINE  = 1'b0;
	localparam logic SEG_CURVE = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [OUT_W-1:0] from_x;
		logic [OUT_W-1:0] from_y;
		logic [OUT_W-1:0] control_x;
		logic [OUT_W-1:0] control_y;
		logic [OUT_W-1:0] to_x;
		logic [OUT_W-1:0] to_y;
	} seg_t;

	// Segments caused by one point: none, seg0 alone, or seg0 then seg1.
	typedef struct packed {
		logic any;
		logic two;
		seg_t seg0;
		seg_t seg1;
	} emit_t;

	function automatic seg_t make_seg(input logic kind,
			input logic [OUT_W-1:0] fx, input logic [OUT_W-1:0] fy,
			input logic [OUT_W-1:0] cx, input logic [OUT_W-1:0] cy,
			input logic [OUT_W-1:0] tx, input logic [OUT_W-1:0] ty);
		seg_t s;
		s.kind      = kind;
		s.from_x    = fx;
		s.from_y    = fy;
		s.control_x = cx;
		s.control_y = cy;
		s.to_x      = tx;
		s.to_y      = ty;
		return s;
	endfunction

endpackage

// ===== rtl/core/gcsd_in_stage.sv =====
// Offset registers and input register of the segment decoder.
// Depends on gcsd_pkg.
module gcsd_in_stage import gcsd_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           point_x,
	input  logic [15:0]           point_y,
	input  logic                  on_curve,
	input  logic                  contour_end,
	input  logic                  take,
	output logic                  valid_s1,
	output logic [COORD_BITS-1:0] x_s1,
	output logic [COORD_BITS-1:0] y_s1,
	output logic                  oc_s1,
	output logic                  end_s1
);

	localparam int EXT_W = (COORD_BITS > 16) ? COORD_BITS : 16;

	logic [15:0]      shift_x_q;
	logic [15:0]      shift_y_q;
	logic [EXT_W-1:0] sum_x;
	logic [EXT_W-1:0] sum_y;

	// sign-extend the raw point, zero-extend the offset, wrap to COORD_BITS
	assign sum_x = EXT_W'(signed'(point_x)) + EXT_W'(shift_x_q);
	assign sum_y = EXT_W'(signed'(point_y)) + EXT_W'(shift_y_q);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x_q <= SHIFT_X_RESET;
			shift_y_q <= SHIFT_Y_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SHIFT_X) shift_x_q <= cfg_data;
			if (cfg_index == CFG_SHIFT_Y) shift_y_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1   <= sum_x[COORD_BITS-1:0];
			y_s1   <= sum_y[COORD_BITS-1:0];
			oc_s1  <= on_curve;
			end_s1 <= contour_end;
		end
	end

endmodule

// ===== rtl/core/gcsd_contour.sv =====
// Contour state machine: turns one offset point into zero, one or two segments.
// Depends on gcsd_pkg.
module gcsd_contour import gcsd_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS-1:0] x,
	input  logic [COORD_BITS-1:0] y,
	input  logic                  oc,
	input  logic                  pt_end,
	input  logic                  take,
	output emit_t                 emit
);

	localparam logic [1:0] PH_START   = 2'd0;
	localparam logic [1:0] PH_ANCHOR  = 2'd1;
	localparam logic [1:0] PH_CONTROL = 2'd2;

	logic [1:0]            ph_q, ph_n;
	logic [COORD_BITS-1:0] anc_x_q, anc_y_q, anc_x_n, anc_y_n;
	logic [COORD_BITS-1:0] prior_x_q, prior_y_q;
	logic [COORD_BITS-1:0] first_x_q, first_y_q, first_x_n, first_y_n;
	logic                  first_oc_q, first_oc_n;
	logic [COORD_BITS:0]   sum_px, sum_py, sum_fx, sum_fy;
	logic [COORD_BITS-1:0] mid_px, mid_py, mid_fx, mid_fy;
	logic                  main_v;
	seg_t                  main_seg, close_seg;

	assign first_x_n  = (ph_q == PH_START) ? x  : first_x_q;
	assign first_y_n  = (ph_q == PH_START) ? y  : first_y_q;
	assign first_oc_n = (ph_q == PH_START) ? oc : first_oc_q;

	// implied midpoints, taken on the unwrapped sum
	assign sum_px = {1'b0, prior_x_q} + {1'b0, x};
	assign sum_py = {1'b0, prior_y_q} + {1'b0, y};
	assign sum_fx = {1'b0, x} + {1'b0, first_x_n};
	assign sum_fy = {1'b0, y} + {1'b0, first_y_n};
	assign mid_px = sum_px[COORD_BITS:1];
	assign mid_py = sum_py[COORD_BITS:1];
	assign mid_fx = sum_fx[COORD_BITS:1];
	assign mid_fy = sum_fy[COORD_BITS:1];

	always_comb begin
		ph_n     = ph_q;
		anc_x_n  = anc_x_q;
		anc_y_n  = anc_y_q;
		main_v   = 1'b0;
		main_seg = '0;
		unique case (ph_q)
			PH_START: begin
				anc_x_n = x;
				anc_y_n = y;
				ph_n    = PH_ANCHOR;
			end
			PH_ANCHOR: begin
				if (oc) begin
					main_v   = 1'b1;
					main_seg = make_seg(SEG_LINE, OUT_W'(anc_x_q), OUT_W'(anc_y_q),
						'0, '0, OUT_W'(x), OUT_W'(y));
					anc_x_n  = x;
					anc_y_n  = y;
				end else begin
					ph_n = PH_CONTROL;
				end
			end
			default: begin
				// pending control point; the unused code behaves the same
				main_v = 1'b1;
				if (oc) begin
					main_seg = make_seg(SEG_CURVE, OUT_W'(anc_x_q), OUT_W'(anc_y_q),
						OUT_W'(prior_x_q), OUT_W'(prior_y_q), OUT_W'(x), OUT_W'(y));
					anc_x_n  = x;
					anc_y_n  = y;
					ph_n     = PH_ANCHOR;
				end else begin
					main_seg = make_seg(SEG_CURVE, OUT_W'(anc_x_q), OUT_W'(anc_y_q),
						OUT_W'(prior_x_q), OUT_W'(prior_y_q),
						OUT_W'(mid_px), OUT_W'(mid_py));
					anc_x_n  = mid_px;
					anc_y_n  = mid_py;
					ph_n     = PH_CONTROL;
				end
			end
		endcase

		// closing segment back to the first point of the contour
		if (ph_n == PH_CONTROL) begin
			if (first_oc_n) begin
				close_seg = make_seg(SEG_CURVE, OUT_W'(anc_x_n), OUT_W'(anc_y_n),
					OUT_W'(x), OUT_W'(y), OUT_W'(first_x_n), OUT_W'(first_y_n));
			end else begin
				close_seg = make_seg(SEG_CURVE, OUT_W'(anc_x_n), OUT_W'(anc_y_n),
					OUT_W'(x), OUT_W'(y), OUT_W'(mid_fx), OUT_W'(mid_fy));
			end
		end else begin
			close_seg = make_seg(SEG_LINE, OUT_W'(x), OUT_W'(y), '0, '0,
				OUT_W'(first_x_n), OUT_W'(first_y_n));
		end

		if (pt_end) ph_n = PH_START;
	end

	assign emit.any  = main_v || pt_end;
	assign emit.two  = main_v && pt_end;
	assign emit.seg0 = main_v ? main_seg : close_seg;
	assign emit.seg1 = close_seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= PH_START;
			anc_x_q    <= '0;
			anc_y_q    <= '0;
			prior_x_q  <= '0;
			prior_y_q  <= '0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			first_oc_q <= 1'b0;
		end else if (take) begin
			ph_q       <= ph_n;
			anc_x_q    <= anc_x_n;
			anc_y_q    <= anc_y_n;
			prior_x_q  <= x;
			prior_y_q  <= y;
			first_x_q  <= first_x_n;
			first_y_q  <= first_y_n;
			first_oc_q <= first_oc_n;
		end
	end

endmodule

// ===== rtl/core/gcsd_out_stage.sv =====
// Result register: holds the segments of one point and sends them one word at a time.
// Depends on gcsd_pkg.
module gcsd_out_stage import gcsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  emit_t       emit,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [95:0] out_data,
	output logic        out_last,
	output logic        out_kind
);

	logic valid_s2;
	logic sel_s2;
	logic two_s2;
	seg_t seg_a_s2;
	seg_t seg_b_s2;
	seg_t shown;

	assign shown     = sel_s2 ? seg_b_s2 : seg_a_s2;
	assign out_valid = valid_s2;
	assign out_last  = !two_s2 || sel_s2;
	assign out_kind  = shown.kind;
	assign out_data  = {shown.to_y, shown.to_x, shown.control_y, shown.control_x,
		shown.from_y, shown.from_x};
	assign room      = !valid_s2 || (out_ready && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sel_s2   <= 1'b0;
			two_s2   <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			sel_s2   <= 1'b0;
			two_s2   <= emit.two;
		end else if (valid_s2 && out_ready) begin
			if (out_last) valid_s2 <= 1'b0;
			else          sel_s2   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seg_a_s2 <= emit.seg0;
			seg_b_s2 <= emit.seg1;
		end
	end

endmodule

// ===== rtl/core/glyph_contour_segment_decoder.sv =====
// Top level of the glyph contour segment decoder: outline points in, segments out.
// Depends on gcsd_pkg, gcsd_in_stage, gcsd_contour and gcsd_out_stage.
//
//  channel  | direction | handshake                | carries
//  ---------+-----------+--------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready     | one outline point per word
//  m_axis   | out       | m_axis_tvalid/tready     | one line or curve segment per word
//  cfg      | in        | cfg_valid/cfg_ready      | offset register writes
//
// A point is registered on entry, decoded combinationally and its segments land in the
// result register, from which the first segment shows on m_axis.
// Points causing zero or one segment go at one per cycle while m_axis is ready; one causing two
// segments (a contour end after a line or curve) holds the result register until both are taken.
// While a finished segment waits on m_axis, words that cause no segment keep passing;
// a word that causes one holds in the input register until the result register frees.
// Reset clears the contour state to "awaiting contour start" and the offsets to 0 and 30.
module glyph_contour_segment_decoder import gcsd_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	// point input
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // point_x[15:0], point_y[31:16]
	input  logic                 s_axis_tuser,  // on_curve
	input  logic                 s_axis_tlast,  // contour_end
	// segment output
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [95:0]          m_axis_tdata,  // from_x, from_y, control_x, control_y,
	                                            // to_x, to_y, 16 bits each from bit 0
	output logic                 m_axis_tuser,  // segment_kind
	output logic                 m_axis_tlast   // last
);

	logic                  valid_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic                  oc_s1;
	logic                  end_s1;
	logic                  take;
	logic                  room;
	emit_t                 emit;

	// offset registers are always writable; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// advance the registered point when it causes no segment or its segments fit in the result register
	assign take = valid_s1 && (!emit.any || room);

	gcsd_in_stage #(.COORD_BITS(COORD_BITS)) u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.point_x     (s_axis_tdata[15:0]),
		.point_y     (s_axis_tdata[31:16]),
		.on_curve    (s_axis_tuser),
		.contour_end (s_axis_tlast),
		.take        (take),
		.valid_s1    (valid_s1),
		.x_s1        (x_s1),
		.y_s1        (y_s1),
		.oc_s1       (oc_s1),
		.end_s1      (end_s1)
	);

	gcsd_contour #(.COORD_BITS(COORD_BITS)) u_contour (
		.clk    (clk),
		.arst_n (arst_n),
		.x      (x_s1),
		.y      (y_s1),
		.oc     (oc_s1),
		.pt_end (end_s1),
		.take   (take),
		.emit   (emit)
	);

	gcsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && emit.any),
		.emit      (emit),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_kind  (m_axis_tuser)
	);

endmodule

// ===== rtl/core/gcsd_checker.sv =====
// Port-level checks of the segment decoder, bound to the top level.
// Depends on gcsd_pkg and glyph_contour_segment_decoder.
module gcsd_checker import gcsd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled segment holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("segment changed while stalled");

	// lines carry a zero control point
	a_line_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == SEG_LINE |-> m_axis_tdata[63:32] == 32'd0)
		else $error("line with nonzero control point");

	// the closing segment follows at once
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("second segment of a point missing");

	// the closing segment starts where the first one ended
	a_pair_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tdata[31:0] == $past(m_axis_tdata[95:64]))
		else $error("closing segment does not continue the contour");

endmodule

bind glyph_contour_segment_decoder gcsd_checker u_gcsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== test/gcsd_segment_checker.sv =====
`timescale 1ns / 1ps
// Segment checker for the glyph contour segment decoder testbench.
// Watches the config, point and segment channels and predicts every segment word.
// Depends on gcsd_pkg.
module gcsd_segment_checker import gcsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // point_x[15:0], point_y[31:16]
	input  logic                 s_axis_tuser,  // on_curve
	input  logic                 s_axis_tlast,  // contour_end
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [95:0]          m_axis_tdata,  // from_x, from_y, control_x, control_y,
	                                            // to_x, to_y, 16 bits each from bit 0
	input  logic                 m_axis_tuser,  // segment_kind
	input  logic                 m_axis_tlast,  // last
	output int                   pending,
	output int                   failures
);

	typedef enum logic [1:0] {
		AWAIT_START,
		ANCHORED,
		PENDING_CTRL
	} contour_phase_t;

	typedef struct packed {
		seg_t seg;
		logic last;
	} segment_word_t;

	logic [15:0]    off_x, off_y;
	contour_phase_t phase;
	logic [15:0]    anchor_x, anchor_y;
	logic [15:0]    prior_x, prior_y;
	logic [15:0]    first_x, first_y;
	logic           first_on;
	segment_word_t  segment_q[$];

	// Average on the 17-bit sum, rounded down.
	function automatic logic [15:0] midpoint(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[16:1];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		failures++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("segment %s got %h, expected %h", name, got, want));
	endtask

	task automatic push_segment(input logic kind, input logic [15:0] fx, input logic [15:0] fy,
			input logic [15:0] cx, input logic [15:0] cy,
			input logic [15:0] tx, input logic [15:0] ty);
		segment_word_t w;
		w.seg.kind      = kind;
		w.seg.from_x    = fx;
		w.seg.from_y    = fy;
		w.seg.control_x = cx;
		w.seg.control_y = cy;
		w.seg.to_x      = tx;
		w.seg.to_y      = ty;
		w.last          = 1'b0;
		segment_q.push_back(w);
	endtask

	task automatic decode_point(input logic [31:0] word, input logic oc, input logic closes);
		logic [15:0] x, y, mx, my;
		int          before_n;
		before_n = segment_q.size();
		x = word[15:0] + off_x;
		y = word[31:16] + off_y;
		case (phase)
		AWAIT_START: begin
			anchor_x = x;
			anchor_y = y;
			first_x  = x;
			first_y  = y;
			first_on = oc;
			phase    = ANCHORED;
		end
		ANCHORED: begin
			if (oc) begin
				push_segment(SEG_LINE, anchor_x, anchor_y, 16'd0, 16'd0, x, y);
				anchor_x = x;
				anchor_y = y;
			end else begin
				phase = PENDING_CTRL;
			end
		end
		default: begin
			if (oc) begin
				push_segment(SEG_CURVE, anchor_x, anchor_y, prior_x, prior_y, x, y);
				anchor_x = x;
				anchor_y = y;
				phase    = ANCHORED;
			end else begin
				mx = midpoint(prior_x, x);
				my = midpoint(prior_y, y);
				push_segment(SEG_CURVE, anchor_x, anchor_y, prior_x, prior_y, mx, my);
				anchor_x = mx;
				anchor_y = my;
			end
		end
		endcase
		// closing segment back to the contour's first point
		if (closes) begin
			if (phase == PENDING_CTRL) begin
				if (first_on)
					push_segment(SEG_CURVE, anchor_x, anchor_y, x, y, first_x, first_y);
				else
					push_segment(SEG_CURVE, anchor_x, anchor_y, x, y,
						midpoint(x, first_x), midpoint(y, first_y));
			end else begin
				push_segment(SEG_LINE, x, y, 16'd0, 16'd0, first_x, first_y);
			end
			phase = AWAIT_START;
		end
		prior_x = x;
		prior_y = y;
		if (segment_q.size() > before_n)
			segment_q[segment_q.size() - 1].last = 1'b1;
	endtask

	task automatic check_segment();
		segment_word_t w;
		if (segment_q.size() == 0) begin
			report_mismatch($sformatf("segment word %h with nothing outstanding", m_axis_tdata));
		end else begin
			w = segment_q.pop_front();
			compare_field("kind", {15'd0, m_axis_tuser}, {15'd0, w.seg.kind});
			compare_field("from_x", m_axis_tdata[15:0], w.seg.from_x);
			compare_field("from_y", m_axis_tdata[31:16], w.seg.from_y);
			compare_field("control_x", m_axis_tdata[47:32], w.seg.control_x);
			compare_field("control_y", m_axis_tdata[63:48], w.seg.control_y);
			compare_field("to_x", m_axis_tdata[79:64], w.seg.to_x);
			compare_field("to_y", m_axis_tdata[95:80], w.seg.to_y);
			compare_field("last", {15'd0, m_axis_tlast}, {15'd0, w.last});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x    = SHIFT_X_RESET;
			off_y    = SHIFT_Y_RESET;
			phase    = AWAIT_START;
			anchor_x = '0;
			anchor_y = '0;
			prior_x  = '0;
			prior_y  = '0;
			first_x  = '0;
			first_y  = '0;
			first_on = 1'b0;
			segment_q.delete();
			pending  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SHIFT_X)
					off_x = cfg_data;
				else if (cfg_index == CFG_SHIFT_Y)
					off_y = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_point(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_segment();
			pending = segment_q.size();
		end
	end

endmodule

// ===== test/glyph_contour_segment_decoder_tb.sv =====
`timescale 1ns / 1ps
// Top of the glyph contour segment decoder testbench: clock, reset, point and
// offset stimulus, and the verdict. Depends on gcsd_pkg, the block and gcsd_segment_checker.
module glyph_contour_segment_decoder_tb;
	import gcsd_pkg::*;

	localparam int POINTS_PER_PHASE = 200;   // eight offset settings, about 1600 points
	localparam int OFFSET_PHASES    = 8;
	localparam int SETTLE_CYCLES    = 6;     // covers the two-stage pipeline with margin
	localparam int CYCLE_LIMIT      = 200000;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_SHIFT_Y + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;   // point_x[15:0], point_y[31:16]
	logic                 s_axis_tuser;   // on_curve
	logic                 s_axis_tlast;   // contour_end
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [95:0]          m_axis_tdata;   // from_x, from_y, control_x, control_y, to_x, to_y
	logic                 m_axis_tuser;   // segment_kind
	logic                 m_axis_tlast;   // last

	int pending;
	int failures;
	int cycle_count = 0;
	bit no_gaps = 1'b0;   // while set, neither side idles

	glyph_contour_segment_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	gcsd_segment_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.pending       (pending),
		.failures      (failures)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop: a hung handshake or a segment that never arrives ends up here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("glyph_contour_segment_decoder test failed");
			$finish;
		end
	end

	// Segment sink: draw a random stall per word unless no_gaps is set, then hold tready until
	// a word is taken. Raise tready only once per step so no edge sees a glitch.
	initial begin : segment_sink
		int stall;
		bit took;
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(posedge clk);
				took = m_axis_tvalid;
			end while (!took);
			@(negedge clk);
		end
	end

	// Send one point word. Call at a falling edge; return at the falling edge after
	// the handshake with tvalid still high, so back-to-back words need no toggle.
	task automatic send_point(input logic [15:0] px, input logic [15:0] py,
			input logic oc, input logic closes);
		int gap;
		bit took;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {py, px};
		s_axis_tuser  <= oc;
		s_axis_tlast  <= closes;
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
			took = s_axis_tready;
		end while (!took);
		@(negedge clk);
	endtask

	// Drop tvalid and wait until every predicted segment has come back, then let
	// points that produce no segment drain out of the pipeline.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		bit took;
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
			took = cfg_ready;
		end while (!took);
		@(negedge clk);
	endtask

	// Write both offsets while idle, plus one write to an index the block ignores.
	task automatic set_offsets(input logic [15:0] sx, input logic [15:0] sy);
		drain();
		write_reg(CFG_SHIFT_X, sx);
		write_reg(CFG_SHIFT_Y, sy);
		write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
			16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Favor the corners of the signed and unsigned ranges; otherwise any 16-bit pattern.
	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 7))
		0:       return 16'h8000;
		1:       return 16'h7FFF;
		2:       return 16'hFFFF;
		3:       return 16'h0000;
		default: return 16'($urandom);
		endcase
	endfunction

	// A well-formed contour: random points, end flag on the last one only.
	task automatic send_contour(input int len);
		for (int i = 0; i < len; i++)
			send_point(pick_coord(), pick_coord(), 1'($urandom), i == len - 1);
	endtask

	initial begin : stimulus
		int sent;
		int len;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, first under the reset offsets.
		// One-point contours: on-curve and off-curve both close with a zero-length line.
		send_point(16'h0000, 16'h0000, 1'b1, 1'b1);
		send_point(16'h7FFF, 16'h8000, 1'b0, 1'b1);
		// Line, control, curve, then three controls with implied midpoints, and a
		// close from the control phase back to an on-curve first point.
		send_point(16'd100, 16'd200, 1'b1, 1'b0);
		send_point(16'd300, 16'hFFFB, 1'b1, 1'b0);
		send_point(16'd350, 16'd50, 1'b0, 1'b0);
		send_point(16'd400, 16'd10, 1'b1, 1'b0);
		send_point(16'hFF00, 16'd20, 1'b0, 1'b0);
		send_point(16'h0100, 16'd40, 1'b0, 1'b0);
		send_point(16'd7, 16'd9, 1'b0, 1'b1);
		// Off-curve first point stays the anchor; close to the midpoint with it.
		send_point(16'h8000, 16'h8000, 1'b0, 1'b0);
		send_point(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
		send_point(16'h8000, 16'h7FFF, 1'b0, 1'b1);
		// Line then closing line, two segments from one point.
		send_point(16'd5, 16'd6, 1'b1, 1'b0);
		send_point(16'd8, 16'd9, 1'b1, 1'b1);
		// Curve ending on an on-curve point, then closing line from it.
		send_point(16'd1, 16'd2, 1'b1, 1'b0);
		send_point(16'd3, 16'd4, 1'b0, 1'b0);
		send_point(16'd5, 16'd6, 1'b1, 1'b1);

		// Largest offsets: wrap every nonzero coordinate and push midpoint sums past 16 bits.
		set_offsets(16'hFFFF, 16'hFFFF);
		send_point(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		send_point(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		send_point(16'hFFFE, 16'h7FFF, 1'b0, 1'b0);
		send_point(16'h7FFF, 16'hFFFF, 1'b1, 1'b0);
		send_point(16'h0000, 16'h8000, 1'b0, 1'b1);

		// Random part: mostly whole contours, some loose points with random flags.
		for (int ph = 0; ph < OFFSET_PHASES; ph++) begin
			case (ph)
			0:       set_offsets(16'h0000, 16'h0000);
			1:       set_offsets(16'hFFFF, 16'hFFFF);
			2:       set_offsets(16'hFFFF, 16'h0000);
			3:       set_offsets(16'h0000, 16'hFFFF);
			default: set_offsets(16'($urandom), 16'($urandom));
			endcase
			// one phase at full rate on both sides
			no_gaps = (ph == 4);
			sent = 0;
			while (sent < POINTS_PER_PHASE) begin
				if ($urandom_range(0, 7) == 0) begin
					send_point(pick_coord(), pick_coord(), 1'($urandom), 1'($urandom));
					sent++;
				end else begin
					len = $urandom_range(1, 8);
					send_contour(len);
					sent += len;
				end
				// Now and then hold the sender until the pipeline is empty.
				if ($urandom_range(0, 39) == 0)
					drain();
			end
			no_gaps = 1'b0;
		end

		drain();
		if (failures == 0) begin
			$display("glyph_contour_segment_decoder test passed");
		end else begin
			$display("glyph_contour_segment_decoder test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/gcsd_pkg.sv
rtl/core/gcsd_in_stage.sv
rtl/core/gcsd_contour.sv
rtl/core/gcsd_out_stage.sv
rtl/core/glyph_contour_segment_decoder.sv
rtl/core/gcsd_checker.sv
test/gcsd_segment_checker.sv
test/glyph_contour_segment_decoder_tb.sv
